>>> hdl/rtcm3_pkg.sv
package rtcm3_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CRC_W    = 24;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned OUT_W    = 80;

    localparam logic [BYTE_W-1:0] PREAMBLE  = 8'hD3;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 24'h864CFB;
    localparam logic [POS_W-1:0]  HDR_BYTES = 11'd3;
    localparam logic [POS_W-1:0]  HDR_CRC_BYTES = 11'd6;
    localparam logic [POS_W-1:0]  MAX_FRAME_RESET = 11'd1029;

    localparam logic [STATUS_W-1:0] ST_DISCARD  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DATA     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_BYTE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd5;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } t_phase;

    // CRC-24Q over one byte, most significant bit first.
    function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data, 16'h0000};
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc[CRC_W-1]) begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> hdl/rtcm3_frame_receiver.sv
// A received word is held in the input register and moves to the result register when that register is free or drained.
// Throughput: one byte per cycle while the sink takes results; the input register and the
// result register let a new word in while a finished result still waits for the sink.
// The frame state, CRC and counters advance in the same cycle a word moves to the result.
// Reset (synchronous, active low) returns to preamble hunting, clears the counters and sets
// the frame limit to 1029 bytes.
module rtcm3_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // data_byte[7:0], byte_index[18:8], status[21:19], payload_len[31:22],
    // good_count[47:32], crc_error_count[63:48], length_error_count[79:64]
    output logic [79:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data        // max_frame_bytes
);
    import rtcm3_pkg::*;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [POS_W-1:0]    r_out_index;
    logic [STATUS_W-1:0] r_out_status;
    logic [LEN_W-1:0]    r_out_flen;

    logic [POS_W-1:0]    r_max_frame;
    t_phase              r_phase;
    logic [POS_W-1:0]    r_byte_pos;
    logic [LEN_W-1:0]    r_payload_len;
    logic [CRC_W-1:0]    r_crc_acc;
    logic [15:0]         r_recv_crc;
    logic [CNT_W-1:0]    r_good_frames;
    logic [CNT_W-1:0]    r_crc_failures;
    logic [CNT_W-1:0]    r_len_failures;

    t_phase              n_phase;
    logic [POS_W-1:0]    n_byte_pos;
    logic [LEN_W-1:0]    n_payload_len;
    logic [CRC_W-1:0]    n_crc_acc;
    logic [15:0]         n_recv_crc;
    logic [CNT_W-1:0]    n_good_frames;
    logic [CNT_W-1:0]    n_crc_failures;
    logic [CNT_W-1:0]    n_len_failures;
    logic [POS_W-1:0]    n_out_index;
    logic [STATUS_W-1:0] n_out_status;
    logic [LEN_W-1:0]    n_out_flen;

    logic                advance;
    logic [CRC_W-1:0]    crc_step;
    logic [POS_W-1:0]    payload_end;
    logic [POS_W-1:0]    crc_offset;
    logic [LEN_W-1:0]    full_len;
    logic [POS_W-1:0]    frame_total;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    assign crc_step    = crc24q_byte(r_crc_acc, r_in_byte);
    assign payload_end = HDR_BYTES + {1'b0, r_payload_len};
    assign crc_offset  = r_byte_pos - payload_end;
    assign full_len    = {r_payload_len[9:8], r_in_byte};
    assign frame_total = HDR_CRC_BYTES + {1'b0, full_len};

    always_comb begin
        n_phase        = r_phase;
        n_byte_pos     = r_byte_pos;
        n_payload_len  = r_payload_len;
        n_crc_acc      = r_crc_acc;
        n_recv_crc     = r_recv_crc;
        n_good_frames  = r_good_frames;
        n_crc_failures = r_crc_failures;
        n_len_failures = r_len_failures;
        n_out_index    = '0;
        n_out_status   = ST_DISCARD;
        n_out_flen     = '0;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == PREAMBLE) begin
                    n_crc_acc     = crc24q_byte('0, r_in_byte);
                    n_recv_crc    = '0;
                    n_payload_len = '0;
                    n_byte_pos    = 11'd1;
                    n_phase       = PH_LEN;
                    n_out_status  = ST_DATA;
                end
            end
            PH_LEN: begin
                n_crc_acc = crc_step;
                if (r_byte_pos == 11'd1) begin
                    n_payload_len = {r_in_byte[1:0], 8'h00};
                    n_out_index   = 11'd1;
                    n_out_status  = ST_DATA;
                    n_byte_pos    = 11'd2;
                end else begin
                    n_out_index = 11'd2;
                    n_out_flen  = full_len;
                    if (frame_total > r_max_frame) begin
                        n_out_status   = ST_TOO_LONG;
                        n_len_failures = r_len_failures + 1'b1;
                        n_phase        = PH_HUNT;
                        n_byte_pos     = '0;
                        n_payload_len  = '0;
                    end else begin
                        n_payload_len = full_len;
                        n_out_status  = ST_DATA;
                        n_byte_pos    = HDR_BYTES;
                        n_phase       = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                // An empty payload drops the byte after the header without testing it.
                if (r_payload_len == '0 || r_byte_pos >= payload_end) begin
                    n_phase       = PH_HUNT;
                    n_byte_pos    = '0;
                    n_payload_len = '0;
                end else begin
                    n_crc_acc    = crc_step;
                    n_out_index  = r_byte_pos;
                    n_out_status = ST_DATA;
                    n_out_flen   = r_payload_len;
                    n_byte_pos   = r_byte_pos + 1'b1;
                    if (r_byte_pos + 1'b1 == payload_end) begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                n_out_index = r_byte_pos;
                n_out_flen  = r_payload_len;
                if (crc_offset == 11'd0) begin
                    n_recv_crc   = {8'h00, r_in_byte};
                    n_out_status = ST_CRC_BYTE;
                    n_byte_pos   = r_byte_pos + 1'b1;
                end else if (crc_offset == 11'd1) begin
                    n_recv_crc   = {r_recv_crc[7:0], r_in_byte};
                    n_out_status = ST_CRC_BYTE;
                    n_byte_pos   = r_byte_pos + 1'b1;
                end else begin
                    if ({r_recv_crc, r_in_byte} == r_crc_acc) begin
                        n_out_status  = ST_GOOD;
                        n_good_frames = r_good_frames + 1'b1;
                    end else begin
                        n_out_status   = ST_CRC_ERR;
                        n_crc_failures = r_crc_failures + 1'b1;
                    end
                    n_phase       = PH_HUNT;
                    n_byte_pos    = '0;
                    n_payload_len = '0;
                end
            end
            default: begin
                n_phase       = PH_HUNT;
                n_byte_pos    = '0;
                n_payload_len = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_max_frame    <= MAX_FRAME_RESET;
            r_phase        <= PH_HUNT;
            r_byte_pos     <= '0;
            r_payload_len  <= '0;
            r_crc_acc      <= '0;
            r_recv_crc     <= '0;
            r_good_frames  <= '0;
            r_crc_failures <= '0;
            r_len_failures <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_frame <= i_cfg_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_phase        <= n_phase;
                r_byte_pos     <= n_byte_pos;
                r_payload_len  <= n_payload_len;
                r_crc_acc      <= n_crc_acc;
                r_recv_crc     <= n_recv_crc;
                r_good_frames  <= n_good_frames;
                r_crc_failures <= n_crc_failures;
                r_len_failures <= n_len_failures;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_byte   <= r_in_byte;
            r_out_index  <= n_out_index;
            r_out_status <= n_out_status;
            r_out_flen   <= n_out_flen;
        end
    end

    // The counters move only together with a result, so they are the result's counts.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_len_failures, r_crc_failures, r_good_frames,
                              r_out_flen, r_out_status, r_out_index, r_out_byte};

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status <= ST_TOO_LONG))
        else $error("result status out of range");

    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_DISCARD) |-> (r_out_index == '0 && r_out_flen == '0))
        else $error("discarded word carries a position or length");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_byte_pos == '0 && r_payload_len == '0))
        else $error("hunting with a stale frame position");

    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_good_frames != $past(r_good_frames))
            |-> (r_out_status == ST_GOOD && $past(advance)))
        else $error("good frame count moved without a good frame");

    a_frame_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(advance) &&
         (r_out_status == ST_GOOD || r_out_status == ST_CRC_ERR ||
          r_out_status == ST_TOO_LONG)) |-> (r_phase == PH_HUNT))
        else $error("frame ended without returning to hunt");

endmodule
